// ===== rtl/ctg_pkg.sv =====
// Shared constants, types and a helper function of the cycloid trot gait generator.
package ctg_pkg;

  // Quarter-wave resolution and frame counter width
  localparam int PHASE_STEPS = 1024;
  localparam int FRAME_BITS  = 16;

  // Derived widths
  localparam int JW   = $clog2(PHASE_STEPS + 1);
  localparam int QW   = $clog2(5 * PHASE_STEPS + 1);
  localparam int S8W  = FRAME_BITS + 9;
  localparam int PW   = 17;
  localparam int XDIV_STEPS = 30;
  localparam int XSHIFT = XDIV_STEPS - $clog2(PHASE_STEPS);
  localparam int PDIV_STEPS = 16;
  localparam int CNTW = $clog2(PDIV_STEPS + 1);
  localparam int ADDR_W = 5;

  localparam logic [QW-1:0] PS_Q   = QW'(PHASE_STEPS);
  localparam logic [QW-1:0] PS2_Q  = QW'(2 * PHASE_STEPS);
  localparam logic [QW-1:0] PS3_Q  = QW'(3 * PHASE_STEPS);
  localparam logic [QW-1:0] PS4_Q  = QW'(4 * PHASE_STEPS);

  // Fixed-point constants
  localparam logic [16:0] ONE_Q16    = 17'd65536;
  localparam logic [31:0] INV_TWO_PI = 32'd10430;
  localparam logic [31:0] SIN_A = 32'd1686629713;
  localparam logic [31:0] SIN_B = 32'd693598667;
  localparam logic [31:0] SIN_C = 32'd85569306;
  localparam logic [31:0] SIN_D = 32'd5026994;
  localparam logic [31:0] SIN_E = 32'd172272;

  // Register indexes
  localparam logic [2:0] REG_SWING_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SWING_HEIGHT = 3'd1;
  localparam logic [2:0] REG_SWING_DUTY   = 3'd2;
  localparam logic [2:0] REG_REST_X       = 3'd3;
  localparam logic [2:0] REG_REST_Z       = 3'd4;

  // Request kinds
  localparam logic REQ_START = 1'b0;

  typedef struct packed {
    logic [11:0] swing_width;
    logic [11:0] swing_height;
    logic [8:0]  swing_duty;
    logic [12:0] rest_x;
    logic [12:0] rest_z;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LATCH, OP_START, OP_REST, OP_S8, OP_HELD, OP_PINIT, OP_DIV,
    OP_Q, OP_AINIT, OP_X2, OP_X2B, OP_HMUL, OP_HSUB, OP_VMUL, OP_VFIN,
    OP_ADONE, OP_SUBMUL, OP_KX, OP_SCL1, OP_SCL2, OP_SCL3, OP_SCL4, OP_EMIT,
    OP_ADV
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECIDE, ST_REST, ST_S8, ST_CHECK, ST_HELD, ST_PINIT, ST_PDIV,
    ST_Q, ST_AINIT, ST_XDIV, ST_X2, ST_X2B, ST_HMUL, ST_HSUB, ST_VMUL, ST_VFIN,
    ST_ADONE, ST_SUBMUL, ST_KX, ST_SCL1, ST_SCL2, ST_SCL3, ST_SCL4, ST_EMIT,
    ST_ADV
  } state_t;

  typedef struct packed {
    logic req_type;
    logic move_to_rest;
    logic periods_zero;
    logic compute;
    logic psat;
    logic div_last;
    logic j_full;
    logic sel;
    logic h_last;
    logic out_free;
  } status_t;

  // Horner coefficients, innermost step first
  function automatic logic [31:0] horner_coef(input logic [1:0] idx);
    logic [31:0] c;
    case (idx)
      2'd0:    c = SIN_D;
      2'd1:    c = SIN_C;
      2'd2:    c = SIN_B;
      default: c = SIN_A;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/ctg_regs.sv =====
// Configuration register file behind the APB-style port.
module ctg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ctg_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output ctg_pkg::cfg_t              cfg
);
  import ctg_pkg::*;

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  // Register writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.swing_width  <= 12'd400;
      cfg.swing_height <= 12'd300;
      cfg.swing_duty   <= 9'd128;
      cfg.rest_x       <= 13'd0;
      cfg.rest_z       <= 13'd0;
    end else if (wr) begin
      case (idx)
        REG_SWING_WIDTH:  cfg.swing_width  <= pwdata[11:0];
        REG_SWING_HEIGHT: cfg.swing_height <= pwdata[11:0];
        REG_SWING_DUTY:   cfg.swing_duty   <= pwdata[8:0];
        REG_REST_X:       cfg.rest_x       <= pwdata[12:0];
        REG_REST_Z:       cfg.rest_z       <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    case (idx)
      REG_SWING_WIDTH:  prdata = {20'd0, cfg.swing_width};
      REG_SWING_HEIGHT: prdata = {20'd0, cfg.swing_height};
      REG_SWING_DUTY:   prdata = {23'd0, cfg.swing_duty};
      REG_REST_X:       prdata = {19'd0, cfg.rest_x};
      REG_REST_Z:       prdata = {19'd0, cfg.rest_z};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/ctg_ctrl.sv =====
// Sequencer that steps the datapath through one request.
module ctg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ctg_pkg::status_t st,
  output ctg_pkg::op_t     op
);
  import ctg_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command
  always_comb begin
    state_next = state;
    op         = OP_NOP;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op         = OP_LATCH;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (st.req_type == REQ_START) begin
          op         = OP_START;
          state_next = st.move_to_rest ? ST_REST : ST_IDLE;
        end else if (st.periods_zero) begin
          state_next = ST_REST;
        end else begin
          state_next = ST_S8;
        end
      end
      ST_REST: begin
        if (st.out_free) begin
          op         = OP_REST;
          state_next = ST_IDLE;
        end
      end
      ST_S8: begin
        op         = OP_S8;
        state_next = ST_CHECK;
      end
      ST_CHECK: state_next = st.compute ? ST_PINIT : ST_HELD;
      ST_HELD: begin
        if (st.out_free) begin
          op         = OP_HELD;
          state_next = ST_ADV;
        end
      end
      ST_PINIT: begin
        op         = OP_PINIT;
        state_next = ST_PDIV;
      end
      ST_PDIV: begin
        if (st.psat) begin
          state_next = ST_Q;
        end else begin
          op = OP_DIV;
          if (st.div_last) state_next = ST_Q;
        end
      end
      ST_Q: begin
        op         = OP_Q;
        state_next = ST_AINIT;
      end
      ST_AINIT: begin
        op         = OP_AINIT;
        state_next = ST_XDIV;
      end
      ST_XDIV: state_next = st.j_full ? ST_ADONE : ST_X2;
      ST_X2: begin
        op         = OP_X2;
        state_next = ST_X2B;
      end
      ST_X2B: begin
        op         = OP_X2B;
        state_next = ST_HMUL;
      end
      ST_HMUL: begin
        op         = OP_HMUL;
        state_next = ST_HSUB;
      end
      ST_HSUB: begin
        op         = OP_HSUB;
        state_next = st.h_last ? ST_VMUL : ST_HMUL;
      end
      ST_VMUL: begin
        op         = OP_VMUL;
        state_next = ST_VFIN;
      end
      ST_VFIN: begin
        op         = OP_VFIN;
        state_next = ST_ADONE;
      end
      ST_ADONE: begin
        op         = OP_ADONE;
        state_next = st.sel ? ST_SUBMUL : ST_AINIT;
      end
      ST_SUBMUL: begin
        op         = OP_SUBMUL;
        state_next = ST_KX;
      end
      ST_KX: begin
        op         = OP_KX;
        state_next = ST_SCL1;
      end
      ST_SCL1: begin
        op         = OP_SCL1;
        state_next = ST_SCL2;
      end
      ST_SCL2: begin
        op         = OP_SCL2;
        state_next = ST_SCL3;
      end
      ST_SCL3: begin
        op         = OP_SCL3;
        state_next = ST_SCL4;
      end
      ST_SCL4: begin
        op         = OP_SCL4;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (st.out_free) begin
          op         = OP_EMIT;
          state_next = ST_ADV;
        end
      end
      ST_ADV: begin
        op         = OP_ADV;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/ctg_dp.sv =====
// Datapath: gait counters, shared multiplier, shift-subtract divider, sine
// polynomial and the output register.
module ctg_dp (
  input  logic             clk,
  input  logic             rst,
  input  ctg_pkg::op_t     op,
  output ctg_pkg::status_t st,
  input  ctg_pkg::cfg_t    cfg,
  input  logic             in_type,
  input  logic [15:0]      in_frames,
  input  logic [14:0]      in_repeat,
  input  logic             in_move,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [55:0]      out_pose,
  output logic             out_fin
);
  import ctg_pkg::*;

  // Latched request
  logic                  lat_type, lat_move;
  logic [15:0]           lat_frames;
  logic [14:0]           lat_repeat;
  // Gait state
  logic [FRAME_BITS-1:0] frame_position, frame_total;
  logic [14:0]           periods_left;
  // Working registers
  logic [S8W-1:0]        s8, rem, dvs;
  logic [XDIV_STEPS-1:0] quo;
  logic [CNTW-1:0]       cnt;
  logic                  swing, psat, j_full, neg, sel;
  logic [PW-1:0]         p, m, kx, kz;
  logic [QW-1:0]         qbase;
  logic [29:0]           x, x2;
  logic [31:0]           t;
  logic [1:0]            hcnt;
  logic signed [17:0]    sn, cs;
  logic [11:0]           tx, tw, th;
  logic [63:0]           prod;
  logic [31:0]           mul_a, mul_b;

  // Combinational helpers
  logic [8:0]            duty_c;
  logic [S8W-1:0]        i8, num;
  logic [S8W:0]          rem2;
  logic                  ge;
  logic [PW-1:0]         p_val;
  logic [QW-1:0]         q0, qc, q;
  logic [1:0]            quad;
  logic [QW-1:0]         r;
  logic [JW-1:0]         j;
  logic [33:0]           vsum;
  logic [19:0]           vq;
  logic [PW-1:0]         mag, sn_mag;
  logic signed [17:0]    aval;
  logic [14:0]           sub_mag;
  logic signed [19:0]    kx_s;
  logic signed [18:0]    kz_s;
  logic [32:0]           rnd;
  logic signed [13:0]    rx, rz, ax, az, bx, bz;
  logic [FRAME_BITS:0]   pos_inc;
  logic                  out_free;

  assign out_free = !out_valid || out_ready;

  // Duty clamped to 1..256
  always_comb begin
    if (cfg.swing_duty == 9'd0) begin
      duty_c = 9'd1;
    end else if (cfg.swing_duty > 9'd256) begin
      duty_c = 9'd256;
    end else begin
      duty_c = cfg.swing_duty;
    end
  end

  assign i8       = S8W'({frame_position, 8'd0});
  assign num      = (i8 <= s8) ? i8 : (i8 - s8);
  assign rem2     = {rem, 1'b0};
  assign ge       = rem2 >= {1'b0, dvs};
  assign p_val    = psat ? ONE_Q16 : {1'b0, quo[15:0]};
  assign pos_inc  = {1'b0, frame_position} + 1'b1;

  // Angle decomposition into quadrant and quarter index
  always_comb begin
    q0 = (prod[14 +: QW] == PS4_Q) ? '0 : prod[14 +: QW];
    if (sel) begin
      qc = qbase + PS_Q;
      if (qc >= PS4_Q) qc = qc - PS4_Q;
      q = qc;
    end else begin
      qc = '0;
      q  = q0;
    end
    if (q >= PS3_Q) begin
      quad = 2'd3;
      r    = q - PS3_Q;
    end else if (q >= PS2_Q) begin
      quad = 2'd2;
      r    = q - PS2_Q;
    end else if (q >= PS_Q) begin
      quad = 2'd1;
      r    = q - PS_Q;
    end else begin
      quad = 2'd0;
      r    = q;
    end
    j = quad[0] ? JW'(PS_Q - r) : JW'(r);
  end

  // Polynomial finish, magnitudes, phase terms and rounding
  always_comb begin
    vsum    = prod[63:30] + 34'd8192;
    vq      = vsum[33:14];
    mag     = j_full ? ONE_Q16 : m;
    aval    = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    sn_mag  = sn[17] ? PW'(-sn) : PW'(sn);
    sub_mag = 15'((prod[31:0] + 32'd32768) >> 16);
    kx_s    = $signed({3'd0, p}) -
              (sn[17] ? -$signed({5'd0, sub_mag}) : $signed({5'd0, sub_mag}));
    kz_s    = $signed({2'd0, ONE_Q16}) - $signed({cs[17], cs});
    rnd     = {1'b0, prod[31:0]} + 33'd32768;
    rx      = {cfg.rest_x[12], cfg.rest_x};
    rz      = {cfg.rest_z[12], cfg.rest_z};
    if (swing) begin
      ax = rx - $signed({2'd0, tx});
      az = rz - $signed({2'd0, th});
      bx = rx - $signed({2'd0, tw});
      bz = rz;
    end else begin
      ax = rx - $signed({2'd0, tw});
      az = rz;
      bx = rx - $signed({2'd0, tx});
      bz = rz - $signed({2'd0, th});
    end
  end

  // Shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_Q:      begin mul_a = 32'(p_val);   mul_b = 32'(PHASE_STEPS); end
      OP_X2:     begin mul_a = {2'd0, quo[29:0]}; mul_b = {2'd0, quo[29:0]}; end
      OP_HMUL:   begin mul_a = {2'd0, x2};   mul_b = t; end
      OP_VMUL:   begin mul_a = {2'd0, x};    mul_b = t; end
      OP_SUBMUL: begin mul_a = 32'(sn_mag);  mul_b = INV_TWO_PI; end
      OP_SCL1:   begin mul_a = 32'(cfg.swing_width);  mul_b = 32'(kx); end
      OP_SCL2:   begin mul_a = 32'(cfg.swing_width);  mul_b = 32'(ONE_Q16 - kx); end
      OP_SCL3:   begin mul_a = 32'(cfg.swing_height); mul_b = 32'(kz); end
      default: ;
    endcase
  end

  // Product register
  always_ff @(posedge clk) begin
    if (op == OP_Q || op == OP_X2 || op == OP_HMUL || op == OP_VMUL ||
        op == OP_SUBMUL || op == OP_SCL1 || op == OP_SCL2 || op == OP_SCL3) begin
      prod <= mul_a * mul_b;
    end
  end

  // Working registers of one frame computation
  always_ff @(posedge clk) begin
    case (op)
      OP_LATCH: begin
        lat_type   <= in_type;
        lat_frames <= in_frames;
        lat_repeat <= in_repeat;
        lat_move   <= in_move;
      end
      OP_S8: s8 <= S8W'(frame_total) * S8W'(duty_c);
      OP_PINIT: begin
        swing <= i8 <= s8;
        psat  <= num >= s8;
        rem   <= num;
        dvs   <= s8;
        cnt   <= CNTW'(PDIV_STEPS);
        sel   <= 1'b0;
      end
      OP_DIV: begin
        rem <= ge ? S8W'(rem2 - {1'b0, dvs}) : rem2[S8W-1:0];
        quo <= {quo[XDIV_STEPS-2:0], ge};
        cnt <= cnt - 1'b1;
      end
      OP_Q: p <= p_val;
      OP_AINIT: begin
        // The table argument j / PHASE_STEPS in Q30 is a plain shift of j.
        if (!sel) qbase <= q0;
        neg    <= quad[1];
        j_full <= j == JW'(PHASE_STEPS);
        quo    <= XDIV_STEPS'({j, {XSHIFT{1'b0}}});
      end
      OP_X2: x <= quo[29:0];
      OP_X2B: begin
        x2   <= prod[59:30];
        t    <= SIN_E;
        hcnt <= 2'd0;
      end
      OP_HSUB: begin
        t    <= horner_coef(hcnt) - prod[61:30];
        hcnt <= hcnt + 1'b1;
      end
      OP_VFIN: m <= (vq > 20'd65535) ? PW'(65535) : PW'(vq);
      OP_ADONE: begin
        if (sel) cs <= aval;
        else     sn <= aval;
        sel <= ~sel;
      end
      OP_KX: begin
        if (kx_s < 0)                          kx <= '0;
        else if (kx_s > $signed({3'd0, ONE_Q16})) kx <= ONE_Q16;
        else                                   kx <= kx_s[PW-1:0];
        kz <= kz_s[PW:1];
      end
      OP_SCL2: tx <= rnd[27:16];
      OP_SCL3: tw <= rnd[27:16];
      OP_SCL4: th <= rnd[27:16];
      default: ;
    endcase
  end

  // Gait counters
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= '0;
      frame_total    <= FRAME_BITS'(1);
      periods_left   <= '0;
    end else if (op == OP_START) begin
      frame_total    <= (lat_frames[FRAME_BITS-1:0] == '0) ? FRAME_BITS'(1)
                                                           : lat_frames[FRAME_BITS-1:0];
      periods_left   <= lat_repeat;
      frame_position <= '0;
    end else if (op == OP_ADV) begin
      if (pos_inc > {1'b0, frame_total}) begin
        frame_position <= '0;
        periods_left   <= periods_left - 1'b1;
      end else begin
        frame_position <= pos_inc[FRAME_BITS-1:0];
      end
    end
  end

  // Output register; every emitted pose is also the held pose
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_pose  <= '0;
      out_fin   <= 1'b0;
    end else begin
      case (op)
        OP_REST: begin
          out_valid <= 1'b1;
          out_pose  <= {rz, rx, rz, rx};
          out_fin   <= lat_type;
        end
        OP_HELD: begin
          out_valid <= 1'b1;
          out_fin   <= 1'b0;
        end
        OP_EMIT: begin
          out_valid <= 1'b1;
          out_pose  <= {bz, bx, az, ax};
          out_fin   <= 1'b0;
        end
        default: if (out_ready) out_valid <= 1'b0;
      endcase
    end
  end

  // Status toward the sequencer
  always_comb begin
    st.req_type     = lat_type;
    st.move_to_rest = lat_move;
    st.periods_zero = periods_left == '0;
    st.compute      = (i8 <= s8) || (frame_position < frame_total);
    st.psat         = psat;
    st.div_last     = cnt == CNTW'(1);
    st.j_full       = j_full;
    st.sel          = sel;
    st.h_last       = hcnt == 2'd3;
    st.out_free     = out_free;
  end

endmodule

// ===== rtl/cycloid_trot_gait_generator.sv =====
// Top level of the cycloid trot gait generator.
//
// Channel | Direction | Transfer                | Payload
// s_*     | in        | s_tvalid & s_tready     | tuser req_type; tdata frames, repeats, rest
// m_*     | out       | m_tvalid & m_tready     | tuser finished; tdata four pose fields
// APB     | in        | psel & penable & pwrite | five gait registers at 4*index
//
// A computed frame runs 16 divider steps for the phase (none when it saturates)
// and sequential Horner passes through one multiplier for the sine and cosine.
// Reset is synchronous and needs no clearing pass. A stalled output holds the
// result; new requests are taken meanwhile and each waits only at its own
// output, the emit, held or rest pose.
module cycloid_trot_gait_generator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [31:0]                s_tdata,  // frames[15:0], repeat_times[30:16], move_to_rest[31]
  input  logic                       s_tuser,  // req_type
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [55:0]                m_tdata,  // pair_a_x, pair_a_z, pair_b_x, pair_b_z, 14 bits each
  output logic                       m_tuser,  // finished
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ctg_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import ctg_pkg::*;

  cfg_t    cfg;
  status_t st;
  op_t     op;

  // Configuration registers
  ctg_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // Sequencer
  ctg_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .st, .op
  );

  // Datapath
  ctg_dp u_dp (
    .clk, .rst, .op, .st, .cfg,
    .in_type(s_tuser), .in_frames(s_tdata[15:0]), .in_repeat(s_tdata[30:16]),
    .in_move(s_tdata[31]),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_pose(m_tdata), .out_fin(m_tuser)
  );

endmodule
